FILE: rtl/rmmsq_pkg.sv
// Package for the range min/max/sum query unit.
// Holds request/result structs, opcodes and identity constants; no dependencies.
`default_nettype none
package rmmsq_pkg;
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_MIN   = 2'd1,
        OP_MAX   = 2'd2,
        OP_SUM   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         first_index;
        logic [9:0]         last_index;
        logic signed [31:0] write_value;
    } t_request;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               bad_range;
    } t_result;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
endpackage
`default_nettype wire

FILE: rtl/range_min_max_sum_query_unit.sv
// Top level of the range min/max/sum query unit; uses rmmsq_pkg.
// Value store in one synchronous RAM, scanned one entry per cycle.
// Write: stored when the request is accepted. Query: the result strobes once the scan ends.
// Bad range: result in the cycle after the request. Busy while a query scans.
// The RAM read port sets the rate. Synchronous reset clears control and length.
// The receiver cannot stall; each result strobes for one cycle.
`default_nettype none
module range_min_max_sum_query_unit
    import rmmsq_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_request i_request,
    input  wire logic     i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    output logic          o_valid,
    output t_result       o_result
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } t_state;

    logic signed [31:0] r_mem [MAX_ENTRIES];
    logic signed [31:0] r_rdata;
    logic [10:0]        r_len;
    t_state             r_state;
    logic [1:0]         r_op;
    logic [AW-1:0]      r_addr, r_hi;
    logic               r_rd_valid;
    logic signed [31:0] r_acc;
    logic               r_valid;
    t_result            r_result;

    logic [16:0] used_len, lo_ext, hi_ext;
    logic        accept, bad;
    logic [AW-1:0] rd_addr;
    logic signed [31:0] n_acc, ident;

    always_comb begin
        used_len = (17'(r_len) > 17'(MAX_ENTRIES)) ? 17'(MAX_ENTRIES) : 17'(r_len);
        lo_ext = 17'(i_request.first_index);
        hi_ext = 17'(i_request.last_index);
        accept = start && (r_state == S_IDLE);
        bad = (used_len == 17'd0) || (hi_ext >= used_len) || (lo_ext > hi_ext);
        rd_addr = (r_state == S_IDLE) ? AW'(i_request.first_index) : r_addr;
        case (r_op)
            OP_MIN:  ident = INT_MAX;
            OP_MAX:  ident = INT_MIN;
            default: ident = 32'sd0;
        endcase
        case (r_op)
            OP_MIN:  n_acc = (r_rdata < r_acc) ? r_rdata : r_acc;
            OP_MAX:  n_acc = (r_rdata > r_acc) ? r_rdata : r_acc;
            default: n_acc = r_acc + r_rdata;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (accept && i_request.opcode == OP_WRITE && lo_ext < used_len) begin
            r_mem[AW'(i_request.first_index)] <= i_request.write_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (r_rd_valid) begin
                r_acc <= n_acc;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_valid <= 1'b0;
                    if (accept && i_request.opcode != OP_WRITE) begin
                        r_op <= i_request.opcode;
                        if (bad) begin
                            r_valid <= 1'b1;
                            r_result.bad_range <= 1'b1;
                            case (i_request.opcode)
                                OP_MIN:  r_result.answer <= INT_MAX;
                                OP_MAX:  r_result.answer <= INT_MIN;
                                default: r_result.answer <= 32'sd0;
                            endcase
                        end else begin
                            r_addr     <= AW'(i_request.first_index) + AW'(1);
                            r_hi       <= AW'(i_request.last_index);
                            r_rd_valid <= 1'b1;
                            r_acc      <= (i_request.opcode == OP_MIN) ? INT_MAX :
                                          (i_request.opcode == OP_MAX) ? INT_MIN : 32'sd0;
                            r_state    <= (AW'(i_request.first_index) ==
                                           AW'(i_request.last_index)) ? S_LAST : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_valid <= 1'b1;
                    if (r_addr == r_hi) begin
                        r_state <= S_LAST;
                    end
                    r_addr <= r_addr + AW'(1);
                end
                S_LAST: begin
                    r_rd_valid         <= 1'b0;
                    r_valid            <= 1'b1;
                    r_result.answer    <= n_acc;
                    r_result.bad_range <= 1'b0;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && !accept) begin
                r_acc <= ident;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule
`default_nettype wire

FILE: tb/tb_range_min_max_sum_query_unit.sv
// Testbench for range_min_max_sum_query_unit: drives write and query requests
// through several active lengths and checks each result against a predictor.
// Depends on rmmsq_pkg and the top level RTL.
`default_nettype none
module tb_range_min_max_sum_query_unit;
    import rmmsq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 1024;
    localparam int CYCLE_CAP  = 800000;
    localparam int IDLE_TAIL  = 4;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    t_request       i_request = '0;
    logic           i_cfg_we = 1'b0;
    logic [10:0]    i_cfg_data = '0;
    logic           o_valid;
    t_result        o_result;

    range_min_max_sum_query_unit #(.MAX_ENTRIES(DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_request  (i_request),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    t_request           request_q[$];
    t_result            answer_q[$];
    logic signed [31:0] shadow_store[DEPTH];
    logic [10:0]        shadow_length = '0;
    bit                 stocked[DEPTH];
    int                 plan_used = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic t_result range_answer(input t_request req);
        t_result    res;
        int         used;
        logic signed [31:0] acc;
        used = (shadow_length > DEPTH) ? DEPTH : int'(shadow_length);
        case (t_opcode'(req.opcode))
            OP_MIN:  acc = INT_MAX;
            OP_MAX:  acc = INT_MIN;
            default: acc = '0;
        endcase
        res.bad_range = 1'b0;
        if (used == 0 || req.last_index >= used || req.first_index > req.last_index) begin
            res.bad_range = 1'b1;
        end else begin
            for (int i = req.first_index; i <= req.last_index; i++) begin
                case (t_opcode'(req.opcode))
                    OP_MIN:  if (shadow_store[i] < acc) acc = shadow_store[i];
                    OP_MAX:  if (shadow_store[i] > acc) acc = shadow_store[i];
                    default: acc = acc + shadow_store[i];
                endcase
            end
        end
        res.answer = acc;
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (request_q.size() > 0) begin
                start <= 1'b1;
                i_request <= request_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, then predict accepted requests
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result", o_result.answer, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (o_result.answer !== want.answer)
                        report_mismatch("answer", o_result.answer, want.answer);
                    if (o_result.bad_range !== want.bad_range)
                        report_mismatch("bad_range", 32'(o_result.bad_range),
                                        32'(want.bad_range));
                end
            end
            if (i_cfg_we) shadow_length <= i_cfg_data;
            if (start && !busy) begin
                if (t_opcode'(i_request.opcode) == OP_WRITE) begin
                    if (i_request.first_index < shadow_length &&
                        i_request.first_index < DEPTH)
                        shadow_store[i_request.first_index] <= i_request.write_value;
                end else begin
                    answer_q = {answer_q, range_answer(i_request)};
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // stock any entry a valid query reads before the query goes out
    task automatic add_request(input t_opcode op, input int lo, input int hi,
                               input logic [31:0] val);
        t_request req;
        t_request fill;
        if (op != OP_WRITE && lo <= hi && hi < plan_used) begin
            for (int i = lo; i <= hi; i++) begin
                if (!stocked[i]) begin
                    fill.opcode = OP_WRITE;
                    fill.first_index = i[9:0];
                    fill.last_index = '0;
                    fill.write_value = pick_value();
                    request_q = {request_q, fill};
                    stocked[i] = 1'b1;
                end
            end
        end
        req.opcode = op;
        req.first_index = lo[9:0];
        req.last_index = hi[9:0];
        req.write_value = val;
        request_q = {request_q, req};
        if (op == OP_WRITE && lo < plan_used) stocked[lo] = 1'b1;
    endtask

    task automatic wait_idle();
        wait (request_q.size() == 0 && !start && answer_q.size() == 0 && !busy);
        repeat (IDLE_TAIL) @(posedge i_clk);
        wait (!busy && answer_q.size() == 0);
    endtask

    // hold off until idle, then program the length
    task automatic set_length(input logic [10:0] len);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        plan_used = (len > DEPTH) ? DEPTH : int'(len);
    endtask

    task automatic random_requests(input int count);
        int lo;
        int hi;
        int n;
        int t;
        n = plan_used;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                add_request(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            pick_value());
            end else begin
                if (n > 0 && $urandom_range(0, 4) != 0) begin
                    if ($urandom_range(0, 1) == 0)
                        lo = $urandom_range(0, (n < 32) ? n - 1 : 31);
                    else
                        lo = $urandom_range((n < 32) ? 0 : n - 32, n - 1);
                    hi = lo + $urandom_range(0, ((n - 1 - lo) < 15) ? (n - 1 - lo) : 15);
                    if (n <= 64 && $urandom_range(0, 40) == 0) begin
                        lo = 0;
                        hi = n - 1;
                    end
                end else begin
                    lo = $urandom_range(0, 1023);
                    hi = $urandom_range(0, 1023);
                    if (n > 0 && $urandom_range(0, 1) == 0) hi = n + $urandom_range(0, 3);
                    if (hi > 1023) hi = 1023;
                    if (hi < n && lo < hi) begin
                        t = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                add_request(t_opcode'($urandom_range(1, 3)), lo, hi, $urandom);
            end
        end
    endtask

    initial begin
        logic [10:0] lengths[7] = '{11'd5, 11'd2047, 11'd37, 11'd700, 11'd1023, 11'd3,
                                    11'd1024};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store: every query is bad, write dropped
        add_request(OP_WRITE, 0, 0, INT_MAX);
        add_request(OP_MIN, 0, 0, '0);
        add_request(OP_MAX, 0, 1023, '1);
        add_request(OP_SUM, 1023, 1023, '0);

        set_length(11'd1);
        add_request(OP_WRITE, 0, 0, INT_MIN);
        add_request(OP_MIN, 0, 0, '0);
        add_request(OP_MAX, 0, 0, '0);
        add_request(OP_SUM, 0, 0, '0);
        add_request(OP_MIN, 0, 1, '0);
        add_request(OP_WRITE, 1, 0, INT_MAX);

        set_length(11'd1024);
        add_request(OP_WRITE, 0, 0, INT_MIN);
        add_request(OP_WRITE, 1023, 1023, INT_MAX);
        add_request(OP_WRITE, 512, 0, INT_MAX);
        add_request(OP_MIN, 0, 15, '0);
        add_request(OP_MAX, 1008, 1023, '0);
        add_request(OP_SUM, 1012, 1023, '0);
        add_request(OP_SUM, 511, 513, '0);
        add_request(OP_MAX, 5, 4, '0);
        add_request(OP_MIN, 1023, 1023, '0);
        add_request(OP_SUM, 1023, 0, '0);
        random_requests(30);

        foreach (lengths[p]) begin
            set_length(lengths[p]);
            random_requests(75);
        end

        set_length(11'd0);
        random_requests(15);

        wait_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
